// ----- sv/mcip_pkg.sv -----
// types, constants and field helpers for the multi-link common info parser
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package mcip_pkg;

  localparam int unsigned NumOptional = 7;
  localparam logic [4:0]  MacEndPos   = 5'd7;
  localparam logic [4:0]  MacLastPos  = 5'd6;

  // subfield kinds, optional ones follow presence bit order
  typedef enum logic [2:0] {
    KIND_MAC  = 3'd0,
    KIND_LINK = 3'd1,
    KIND_CHG  = 3'd2,
    KIND_SYNC = 3'd3,
    KIND_EML  = 3'd4,
    KIND_MLD  = 3'd5,
    KIND_APID = 3'd6,
    KIND_EXT  = 3'd7
  } mcip_kind_e;

  // result codes
  localparam logic [4:0] CodeMac      = 5'd0;
  localparam logic [4:0] CodeLinkId   = 5'd1;
  localparam logic [4:0] CodeChgCnt   = 5'd2;
  localparam logic [4:0] CodeSyncBase = 5'd3;
  localparam logic [4:0] CodeEmlBase  = 5'd6;
  localparam logic [4:0] CodeMldBase  = 5'd12;
  localparam logic [4:0] CodeApId     = 5'd17;
  localparam logic [4:0] CodeExtBase  = 5'd18;

  // one completed subfield, handed from front to back
  typedef struct packed {
    mcip_kind_e  kind;
    logic [47:0] value;
    logic [4:0]  used;
    logic        last;
    logic        mismatch;
  } mcip_job_t;

  function automatic logic [1:0] sub_size(input logic [2:0] k);
    logic [1:0] s;
    case (k)
      3'd0, 3'd1, 3'd5: s = 2'd1;
      default:          s = 2'd2;
    endcase
    return s;
  endfunction

  function automatic logic [2:0] num_parts(input mcip_kind_e kind);
    logic [2:0] n;
    case (kind)
      KIND_SYNC: n = 3'd3;
      KIND_EML:  n = 3'd6;
      KIND_MLD:  n = 3'd5;
      KIND_EXT:  n = 3'd3;
      default:   n = 3'd1;
    endcase
    return n;
  endfunction

  function automatic logic [4:0] base_code(input mcip_kind_e kind);
    logic [4:0] c;
    case (kind)
      KIND_MAC:  c = CodeMac;
      KIND_LINK: c = CodeLinkId;
      KIND_CHG:  c = CodeChgCnt;
      KIND_SYNC: c = CodeSyncBase;
      KIND_EML:  c = CodeEmlBase;
      KIND_MLD:  c = CodeMldBase;
      KIND_APID: c = CodeApId;
      KIND_EXT:  c = CodeExtBase;
      default:   c = CodeMac;
    endcase
    return c;
  endfunction

  function automatic logic [47:0] part_value(input mcip_kind_e kind, input logic [2:0] part,
                                             input logic [47:0] value);
    logic [15:0] v;
    logic [47:0] r;
    v = value[15:0];
    r = '0;
    case (kind)
      KIND_MAC:  r = value;
      KIND_LINK: r[3:0] = v[3:0];
      KIND_CHG:  r[7:0] = v[7:0];
      KIND_APID: r[7:0] = v[7:0];
      KIND_SYNC: begin
        case (part)
          3'd0:    r[7:0] = v[7:0];
          3'd1:    r[3:0] = v[11:8];
          default: r[3:0] = v[15:12];
        endcase
      end
      KIND_EML: begin
        case (part)
          3'd0:    r[0]   = v[0];
          3'd1:    r[2:0] = v[3:1];
          3'd2:    r[2:0] = v[6:4];
          3'd3:    r[0]   = v[7];
          3'd4:    r[2:0] = v[10:8];
          default: r[3:0] = v[14:11];
        endcase
      end
      KIND_MLD: begin
        case (part)
          3'd0:    r[3:0] = v[3:0];
          3'd1:    r[0]   = v[4];
          3'd2:    r[1:0] = v[6:5];
          3'd3:    r[4:0] = v[11:7];
          default: r[0]   = v[12];
        endcase
      end
      KIND_EXT: begin
        case (part)
          3'd0:    r[0]   = v[0];
          3'd1:    r[3:0] = v[4:1];
          default: r[0]   = v[5];
        endcase
      end
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- sv/mcip_if.sv -----
// valid/ready channel interfaces for the byte input and the subfield output
// no dependencies
`timescale 1ns / 1ps

interface mcip_in_if;
  logic       valid;
  logic       ready;
  logic       start_req;
  logic [6:0] presence_bits;
  logic [7:0] data_byte;

  modport source (output valid, output start_req, output presence_bits, output data_byte,
                  input ready);
  modport sink (input valid, input start_req, input presence_bits, input data_byte,
                output ready);
endinterface

interface mcip_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  field_code;
  logic [47:0] field_value;
  logic        last;
  logic        length_mismatch;
  logic [4:0]  bytes_used;

  modport source (output valid, output field_code, output field_value, output last,
                  output length_mismatch, output bytes_used, input ready);
  modport sink (input valid, input field_code, input field_value, input last,
                input length_mismatch, input bytes_used, output ready);
endinterface

// ----- sv/mcip_front.sv -----
// front end: tracks byte position, assembles multi-byte subfields, emits jobs
// depends on mcip_pkg
`timescale 1ns / 1ps

module mcip_front
  import mcip_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic       start_i,
  input  logic [6:0] presence_i,
  input  logic [7:0] byte_i,
  output logic       job_valid_o,
  output mcip_job_t  job_o
);

  logic        active_q, active_d;
  logic [4:0]  pos_q, pos_d;
  logic [6:0]  pres_q, pres_d;
  logic [7:0]  dlen_q, dlen_d;
  logic [47:0] asm_q, asm_d;

  logic [4:0]  used;
  logic [4:0]  end_pos;
  logic        found;
  logic [2:0]  which;
  logic        off_hi;
  logic        in_mac;

  // locate subfield holding the current byte and the field end
  always_comb begin
    logic [4:0] fs;
    logic [4:0] en;
    fs     = '0;
    en     = MacEndPos;
    found  = 1'b0;
    which  = '0;
    off_hi = 1'b0;
    for (int k = 0; k < NumOptional; k++) begin
      if (pres_q[k]) begin
        fs = en;
        en = en + {3'b0, sub_size(3'(k))};
        if (pos_q >= fs && pos_q < en) begin
          found  = 1'b1;
          which  = 3'(k);
          off_hi = (pos_q != fs);
        end
      end
    end
    end_pos = en;
  end

  assign used   = pos_q + 5'd1;
  assign in_mac = (pos_q < MacEndPos);

  always_comb begin
    active_d    = active_q;
    pos_d       = pos_q;
    pres_d      = pres_q;
    dlen_d      = dlen_q;
    asm_d       = asm_q;
    job_valid_o = 1'b0;
    job_o.kind     = KIND_MAC;
    job_o.value    = {asm_q[39:0], byte_i};
    job_o.used     = used;
    job_o.last     = (used >= end_pos);
    job_o.mismatch = (dlen_q != {3'b0, end_pos});
    if (accept_i) begin
      if (start_i) begin
        active_d = 1'b1;
        pres_d   = presence_i;
        dlen_d   = byte_i;
        pos_d    = 5'd1;
        asm_d    = '0;
      end else if (active_q) begin
        pos_d = used;
        if (used >= end_pos) begin
          active_d = 1'b0;
        end
        if (in_mac) begin
          asm_d       = {asm_q[39:0], byte_i};
          job_valid_o = (pos_q == MacLastPos);
        end else if (!found) begin
          active_d = 1'b0;
        end else if (sub_size(which) == 2'd2 && !off_hi) begin
          // low byte of a little-endian pair
          asm_d = {40'b0, byte_i};
        end else begin
          job_valid_o = 1'b1;
          job_o.kind  = mcip_kind_e'(which + 3'd1);
          job_o.value = (sub_size(which) == 2'd2) ? {32'b0, byte_i, asm_q[7:0]}
                                                  : {40'b0, byte_i};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      pos_q    <= '0;
      pres_q   <= '0;
      dlen_q   <= '0;
      asm_q    <= '0;
    end else begin
      active_q <= active_d;
      pos_q    <= pos_d;
      pres_q   <= pres_d;
      dlen_q   <= dlen_d;
      asm_q    <= asm_d;
    end
  end

endmodule

// ----- sv/mcip_queue.sv -----
// small job queue between front and back
// depends on mcip_pkg
`timescale 1ns / 1ps

module mcip_queue
  import mcip_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  mcip_job_t push_data_i,
  input  logic      pop_i,
  output logic      full_o,
  output logic      valid_o,
  output mcip_job_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);
  localparam logic [PtrW-1:0] PtrOne  = PtrW'(1);
  localparam logic [CntW-1:0] CntOne  = CntW'(1);

  mcip_job_t       mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + PtrOne;
    end
    if (do_pop) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + PtrOne;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntOne;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntOne;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- sv/mcip_back.sv -----
// back end: splits each job into its code/value result beats
// depends on mcip_pkg and mcip_if
`timescale 1ns / 1ps

module mcip_back
  import mcip_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      job_valid_i,
  input  mcip_job_t job_i,
  output logic      pop_o,
  mcip_out_if.source out_o
);

  logic [2:0] part_q, part_d;
  logic       final_part;
  logic       fire;

  assign final_part = (part_q == num_parts(job_i.kind) - 3'd1);
  assign fire       = out_o.valid && out_o.ready;
  assign pop_o      = fire && final_part;

  assign out_o.valid           = job_valid_i;
  assign out_o.field_code      = base_code(job_i.kind) + {2'b0, part_q};
  assign out_o.field_value     = part_value(job_i.kind, part_q, job_i.value);
  assign out_o.last            = job_i.last && final_part;
  assign out_o.length_mismatch = job_i.last && final_part && job_i.mismatch;
  assign out_o.bytes_used      = job_i.used;

  always_comb begin
    part_d = part_q;
    if (fire) begin
      part_d = final_part ? 3'd0 : part_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_q <= '0;
    end else begin
      part_q <= part_d;
    end
  end

endmodule

// ----- sv/mle_common_info_parser_unit.sv -----
// Common Info parser for the Basic Multi-Link element. Takes one byte per beat: a beat with
// start_req carries the length byte and the presence bitmap, then the six MLD MAC address
// bytes and the optional subfields follow. Each completed subfield comes out as one or more
// code/value beats; the final beat of a field carries last and the length check. The input
// takes a byte every cycle as long as the job queue (QueueDepth entries) has room; the output
// side gives one result beat per cycle while out_o.ready is high, so a byte that completes
// a subfield of n parts holds the back end for n beats (up to six for the EML capabilities)
// and the queue absorbs that. Each job is registered in the queue before its beats appear.
// depends on mcip_pkg, mcip_if, mcip_front, mcip_queue, mcip_back
`timescale 1ns / 1ps

module mle_common_info_parser_unit
  import mcip_pkg::*;
#(
  parameter int unsigned QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mcip_in_if.sink    in_i,
  mcip_out_if.source out_o
);

  logic      full;
  logic      accept;
  logic      job_valid;
  mcip_job_t job;
  logic      head_valid;
  mcip_job_t head;
  logic      pop;

  assign in_i.ready = !full;
  assign accept     = in_i.valid && !full;

  mcip_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .start_i     (in_i.start_req),
    .presence_i  (in_i.presence_bits),
    .byte_i      (in_i.data_byte),
    .job_valid_o (job_valid),
    .job_o       (job)
  );

  mcip_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (job_valid),
    .push_data_i (job),
    .pop_i       (pop),
    .full_o      (full),
    .valid_o     (head_valid),
    .head_o      (head)
  );

  mcip_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (head_valid),
    .job_i       (head),
    .pop_o       (pop),
    .out_o       (out_o)
  );

endmodule

// ----- bench/mle_common_info_parser_unit_tb.sv -----
// self-checking bench for mle_common_info_parser_unit: directed byte table, then random fields
// depends on mcip_pkg, mcip_if and the parser rtl; expected subfield beats come from a local model
`timescale 1ns / 1ps

module mle_common_info_parser_unit_tb;
  import mcip_pkg::*;

  localparam int HoldAt     = 100;   // accepted bytes before the long output hold-off
  localparam int HoldCycles = 80;
  localparam int TailCycles = 40;
  localparam logic [4:0] CodeNstrUpd = CodeExtBase + 5'd2;

  typedef struct packed {
    logic [4:0]  code;
    logic [47:0] value;
    logic        last;
    logic        mismatch;
    logic [4:0]  used;
  } subfield_t;

  typedef struct packed {
    logic       start;
    logic [6:0] presence;
    logic [7:0] data;
    logic       pinned;
    subfield_t  want;
  } byte_item_t;

  logic clk_i;
  logic rst_ni;

  mcip_in_if  in_bus ();
  mcip_out_if out_bus ();

  mle_common_info_parser_unit dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  // optional subfield sizes in presence bit order
  int subfield_len [7] = '{1, 1, 2, 2, 2, 1, 2};

  subfield_t  subfield_q [$];
  byte_item_t byte_q [$];
  int errors   = 0;
  int accepted = 0;
  logic hold_on = 1'b0;
  logic calm    = 1'b0;

  // parser model state
  logic        p_active   = 1'b0;
  logic [4:0]  p_pos      = '0;
  logic [6:0]  p_presence = '0;
  logic [7:0]  p_length   = '0;
  logic [47:0] p_asm      = '0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic subfield_t make_beat(input logic [4:0] code, input logic [47:0] value,
                                          input logic last, input logic mismatch,
                                          input logic [4:0] used);
    subfield_t s;
    s.code     = code;
    s.value    = value;
    s.last     = last;
    s.mismatch = mismatch;
    s.used     = used;
    return s;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic report_mismatch(input string what, input logic [47:0] got,
                                 input logic [47:0] want);
    if (errors < 50)
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic emit(input logic [4:0] code, input logic [47:0] value, input int used);
    subfield_q.push_back(make_beat(code, value, 1'b0, 1'b0, 5'(used)));
  endtask

  // advances the model by one accepted byte and queues the beats it produces
  task automatic parse_byte(input logic start, input logic [6:0] presence, input logic [7:0] b);
    int idx, used, field_end, fs, off, which, n0, k;
    logic [15:0] v;
    subfield_t tail;
    if (start) begin
      p_active   = 1'b1;
      p_presence = presence;
      p_length   = b;
      p_pos      = 5'd1;
      p_asm      = '0;
      return;
    end
    if (!p_active) return;
    idx   = p_pos;
    used  = idx + 1;
    p_pos = 5'(used);
    which = -1;
    off   = (idx < 7) ? idx - 1 : 0;
    field_end = 7;
    for (k = 0; k < 7; k++) begin
      if (p_presence[k]) begin
        fs = field_end;
        field_end += subfield_len[k];
        if (idx >= fs && idx < field_end) begin
          which = k;
          off   = idx - fs;
        end
      end
    end
    n0 = subfield_q.size();
    v  = {b, p_asm[7:0]};
    if (idx < 7) begin
      p_asm = {p_asm[39:0], b};
      if (off == 5) emit(CodeMac, p_asm, used);
    end else if (which < 0) begin
      p_active = 1'b0;
      return;
    end else if (subfield_len[which] == 2 && off == 0) begin
      p_asm = {40'd0, b};
    end else begin
      case (mcip_kind_e'(3'(which + 1)))
        KIND_LINK: emit(CodeLinkId, 48'(b[3:0]), used);
        KIND_CHG:  emit(CodeChgCnt, 48'(b), used);
        KIND_SYNC: begin
          emit(CodeSyncBase,        48'(p_asm[7:0]), used);
          emit(CodeSyncBase + 5'd1, 48'(b[3:0]), used);
          emit(CodeSyncBase + 5'd2, 48'(b[7:4]), used);
        end
        KIND_EML: begin
          emit(CodeEmlBase,        48'(v[0]), used);
          emit(CodeEmlBase + 5'd1, 48'(v[3:1]), used);
          emit(CodeEmlBase + 5'd2, 48'(v[6:4]), used);
          emit(CodeEmlBase + 5'd3, 48'(v[7]), used);
          emit(CodeEmlBase + 5'd4, 48'(v[10:8]), used);
          emit(CodeEmlBase + 5'd5, 48'(v[14:11]), used);
        end
        KIND_MLD: begin
          emit(CodeMldBase,        48'(v[3:0]), used);
          emit(CodeMldBase + 5'd1, 48'(v[4]), used);
          emit(CodeMldBase + 5'd2, 48'(v[6:5]), used);
          emit(CodeMldBase + 5'd3, 48'(v[11:7]), used);
          emit(CodeMldBase + 5'd4, 48'(v[12]), used);
        end
        KIND_APID: emit(CodeApId, 48'(b), used);
        default: begin
          emit(CodeExtBase,        48'(v[0]), used);
          emit(CodeExtBase + 5'd1, 48'(v[4:1]), used);
          emit(CodeExtBase + 5'd2, 48'(v[5]), used);
        end
      endcase
    end
    if (used >= field_end) begin
      p_active = 1'b0;
      if (subfield_q.size() > n0) begin
        tail = subfield_q[subfield_q.size() - 1];
        tail.last     = 1'b1;
        tail.mismatch = (p_length != field_end);
        subfield_q[subfield_q.size() - 1] = tail;
      end
    end
  endtask

  task automatic add_row(input logic start, input logic [6:0] presence, input logic [7:0] data,
                         input logic pinned, input subfield_t want);
    byte_item_t it;
    it.start    = start;
    it.presence = presence;
    it.data     = data;
    it.pinned   = pinned;
    it.want     = want;
    byte_q.push_back(it);
  endtask

  task automatic build_directed();
    int i;
    // stray byte while idle, then a field cut short by a new start
    add_row(1'b0, 7'h7f, 8'haa, 1'b0, '0);
    add_row(1'b1, 7'h7f, 8'hff, 1'b0, '0);
    add_row(1'b0, 7'h00, 8'h12, 1'b0, '0);
    // every optional subfield present, length byte 0 so the check trips
    add_row(1'b1, 7'h7f, 8'h00, 1'b0, '0);
    for (i = 0; i < 5; i++) add_row(1'b0, 7'h00, 8'hff, 1'b0, '0);
    add_row(1'b0, 7'h00, 8'hff, 1'b1,
            make_beat(CodeMac, 48'hffff_ffff_ffff, 1'b0, 1'b0, 5'd7));
    add_row(1'b0, 7'h00, 8'hff, 1'b0, '0);  // link id
    add_row(1'b0, 7'h00, 8'h00, 1'b0, '0);  // change count
    add_row(1'b0, 7'h00, 8'ha5, 1'b0, '0);  // medium sync delay
    add_row(1'b0, 7'h00, 8'h5a, 1'b0, '0);
    add_row(1'b0, 7'h00, 8'hff, 1'b0, '0);  // eml caps
    add_row(1'b0, 7'h00, 8'hff, 1'b0, '0);
    add_row(1'b0, 7'h00, 8'h00, 1'b0, '0);  // mld caps
    add_row(1'b0, 7'h00, 8'h00, 1'b0, '0);
    add_row(1'b0, 7'h00, 8'hff, 1'b0, '0);  // ap mld id
    add_row(1'b0, 7'h00, 8'hff, 1'b0, '0);  // ext mld caps
    add_row(1'b0, 7'h00, 8'hff, 1'b1, make_beat(CodeNstrUpd, 48'd1, 1'b1, 1'b1, 5'd18));
    // past the end of the field
    add_row(1'b0, 7'h00, 8'h55, 1'b0, '0);
  endtask

  task automatic build_random();
    int field_bytes, r, k, nb, field_end;
    logic [6:0] pres;
    logic [7:0] len;
    field_bytes = 0;
    while (field_bytes < 220) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        add_row(1'b0, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)), 1'b0, '0);
      end else begin
        pres = 7'($urandom_range(0, 127));
        field_end = 7;
        for (k = 0; k < 7; k++) if (pres[k]) field_end += subfield_len[k];
        k = $urandom_range(0, 99);
        if (k < 70)      len = 8'(field_end);
        else if (k < 80) len = 8'(field_end + ($urandom_range(0, 1) ? 1 : -1));
        else if (k < 85) len = ($urandom_range(0, 1)) ? 8'h00 : 8'hff;
        else             len = 8'($urandom_range(0, 255));
        add_row(1'b1, pres, len, 1'b0, '0);
        nb = (r < 16) ? $urandom_range(0, field_end - 2) : field_end - 1;
        for (k = 0; k < nb; k++)
          add_row(1'b0, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)), 1'b0, '0);
        field_bytes += nb + 1;
        if ($urandom_range(0, 4) == 0) begin
          nb = $urandom_range(1, 2);
          for (k = 0; k < nb; k++)
            add_row(1'b0, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)), 1'b0, '0);
        end
      end
    end
  endtask

  task automatic check_beat(input subfield_t got);
    subfield_t want;
    if (subfield_q.size() == 0) begin
      report_mismatch("unexpected beat, code", 48'(got.code), '0);
      return;
    end
    want = subfield_q.pop_front();
    if (got.code !== want.code) report_mismatch("field_code", 48'(got.code), 48'(want.code));
    if (got.value !== want.value) report_mismatch("field_value", got.value, want.value);
    if (got.last !== want.last) report_mismatch("last", 48'(got.last), 48'(want.last));
    if (got.mismatch !== want.mismatch)
      report_mismatch("length_mismatch", 48'(got.mismatch), 48'(want.mismatch));
    if (got.used !== want.used) report_mismatch("bytes_used", 48'(got.used), 48'(want.used));
  endtask

  // output side: capture at the rising edge, check and pick ready at the falling edge
  initial begin
    subfield_t seen;
    logic got;
    int stall;
    stall = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      got = out_bus.valid && out_bus.ready;
      seen.code     = out_bus.field_code;
      seen.value    = out_bus.field_value;
      seen.last     = out_bus.last;
      seen.mismatch = out_bus.length_mismatch;
      seen.used     = out_bus.bytes_used;
      @(negedge clk_i);
      if (got === 1'b1) check_beat(seen);
      if (!rst_ni || hold_on) begin
        out_bus.ready = 1'b0;
      end else if (stall > 0) begin
        out_bus.ready = 1'b0;
        stall--;
      end else begin
        out_bus.ready = 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) stall = idle_len();
      end
    end
  end

  // long hold-off on the output while bytes keep coming
  initial begin
    wait (accepted >= HoldAt);
    @(posedge clk_i);
    hold_on = 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_on = 1'b0;
  end

  // input side
  initial begin
    int i, gap, n_directed, mid_pause;
    byte_item_t it;
    in_bus.valid         = 1'b0;
    in_bus.start_req     = 1'b0;
    in_bus.presence_bits = '0;
    in_bus.data_byte     = '0;
    rst_ni = 1'b0;
    build_directed();
    n_directed = byte_q.size();
    build_random();
    mid_pause = n_directed + 150;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    for (i = 0; i < byte_q.size(); i++) begin
      it = byte_q[i];
      calm = (i >= n_directed + 30 && i < n_directed + 60);
      // let everything drain before the random part and once midway
      if ((i == n_directed || i == mid_pause) && subfield_q.size() != 0) begin
        in_bus.valid = 1'b0;
        while (subfield_q.size() != 0) @(negedge clk_i);
      end
      gap = (hold_on || calm) ? 0 : idle_len();
      if (gap > 0) begin
        in_bus.valid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      in_bus.valid         = 1'b1;
      in_bus.start_req     = it.start;
      in_bus.presence_bits = it.presence;
      in_bus.data_byte     = it.data;
      forever begin
        @(posedge clk_i);
        if (in_bus.ready === 1'b1) break;
      end
      parse_byte(it.start, it.presence, it.data);
      if (it.pinned) subfield_q[subfield_q.size() - 1] = it.want;
      accepted++;
      @(negedge clk_i);
    end
    in_bus.valid = 1'b0;
    calm = 1'b0;
    while (subfield_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/mcip_pkg.sv
sv/mcip_if.sv
sv/mcip_front.sv
sv/mcip_queue.sv
sv/mcip_back.sv
sv/mle_common_info_parser_unit.sv
bench/mle_common_info_parser_unit_tb.sv
